/* sv/g6ad_pkg.sv */
// ----------------------------------------------------------------------------
// g6ad_pkg
// Shared types and constants for the graph6 adjacency decoder.
// ----------------------------------------------------------------------------
package g6ad_pkg;

    localparam int unsigned MAX_VERTICES_DEF = 62;
    localparam int unsigned IDX_W            = 6;
    localparam int unsigned BYTE_W           = 8;
    localparam logic [BYTE_W-1:0] CHAR_OFFSET = 8'd63;
    localparam int unsigned BITS_PER_CHAR    = 6;
    localparam logic [2:0]  TOP_BIT          = 3'd5;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    typedef struct packed {
        logic             is_hdr;
        logic [IDX_W-1:0] val;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* sv/g6ad_front.sv */
// ----------------------------------------------------------------------------
// g6ad_front
// Input stage: registers each byte, classifies it as header or data, and
// reduces it to a clamped vertex count or a six-bit payload.
// ----------------------------------------------------------------------------
module g6ad_front import g6ad_pkg::*; #(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_frame_start,
    output logic              o_push,
    output t_cmd              o_cmd,
    input  t_q_status         i_q_status
);

    localparam logic [BYTE_W-1:0] MaxVtx = BYTE_W'(MAX_VERTICES);

    logic              r_valid;
    t_cmd              r_cmd;
    logic              n_valid;
    t_cmd              n_cmd;
    logic              load;
    logic [BYTE_W-1:0] diff;

    assign o_push  = r_valid && !i_q_status.full;
    assign o_stall = r_valid && i_q_status.full;
    assign load    = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_comb begin
        diff         = i_byte_in - CHAR_OFFSET;
        n_cmd.is_hdr = i_frame_start;
        if (i_frame_start) begin
            if (i_byte_in < CHAR_OFFSET) begin
                n_cmd.val = '0;
            end else if (diff > MaxVtx) begin
                n_cmd.val = MaxVtx[IDX_W-1:0];
            end else begin
                n_cmd.val = diff[IDX_W-1:0];
            end
        end else begin
            n_cmd.val = diff[IDX_W-1:0];
        end
        n_valid = load || (r_valid && !o_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* sv/g6ad_queue.sv */
// ----------------------------------------------------------------------------
// g6ad_queue
// Two-entry request queue between the front stage and the expansion stage.
// ----------------------------------------------------------------------------
module g6ad_queue import g6ad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam logic [Q_PTR_W-1:0] LastPtr = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] FullCnt = Q_CNT_W'(Q_DEPTH);

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic [Q_PTR_W-1:0]  n_wr_ptr;
    logic [Q_PTR_W-1:0]  n_rd_ptr;
    logic [Q_CNT_W-1:0]  n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_status.full  = (r_cnt == FullCnt);
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/g6ad_back.sv */
// ----------------------------------------------------------------------------
// g6ad_back
// Expansion stage: holds the graph walk state and turns each data request
// into adjacency results, one per cycle unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module g6ad_back import g6ad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_q_status        i_q_status,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_row,
    output logic [IDX_W-1:0] o_col,
    output logic             o_edge_res,
    output logic             o_last_of_byte,
    output logic             o_graph_done
);

    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_done;
    logic [2:0]       r_k;
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_row;
    logic [IDX_W-1:0] r_o_col;
    logic             r_o_edge;
    logic             r_o_last;
    logic             r_o_gdone;

    logic [IDX_W-1:0] n_n;
    logic [IDX_W-1:0] n_row;
    logic [IDX_W-1:0] n_col;
    logic             n_done;
    logic [2:0]       n_k;
    logic             n_o_valid;
    logic             emit;
    logic             can_emit;
    logic             done_now;
    logic             last_now;
    logic             cur_bit;
    logic [IDX_W-1:0] col_inc;
    logic [IDX_W-1:0] row_inc;

    assign o_valid        = r_o_valid;
    assign o_row          = r_o_row;
    assign o_col          = r_o_col;
    assign o_edge_res     = r_o_edge;
    assign o_last_of_byte = r_o_last;
    assign o_graph_done   = r_o_gdone;

    always_comb begin
        can_emit  = !r_o_valid || !i_stall;
        cur_bit   = i_cmd.val[TOP_BIT - r_k];
        col_inc   = r_col + 1'b1;
        row_inc   = r_row + 1'b1;
        done_now  = (col_inc >= r_row) && (row_inc >= r_n);
        last_now  = (r_k == TOP_BIT) || done_now;
        n_n       = r_n;
        n_row     = r_row;
        n_col     = r_col;
        n_done    = r_done;
        n_k       = r_k;
        emit      = 1'b0;
        o_pop     = 1'b0;
        if (!i_q_status.empty) begin
            if (i_cmd.is_hdr) begin
                n_n    = i_cmd.val;
                n_row  = IDX_W'(1);
                n_col  = '0;
                n_done = (i_cmd.val < IDX_W'(2));
                n_k    = '0;
                o_pop  = 1'b1;
            end else if (r_done) begin
                n_k   = '0;
                o_pop = 1'b1;
            end else if (can_emit) begin
                emit = 1'b1;
                if (col_inc >= r_row) begin
                    n_col = '0;
                    n_row = row_inc;
                end else begin
                    n_col = col_inc;
                end
                if (done_now) begin
                    n_done = 1'b1;
                end
                if (last_now) begin
                    n_k   = '0;
                    o_pop = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
        end
        n_o_valid = emit || (r_o_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_row     <= IDX_W'(1);
            r_col     <= '0;
            r_done    <= 1'b1;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_n       <= n_n;
            r_row     <= n_row;
            r_col     <= n_col;
            r_done    <= n_done;
            r_k       <= n_k;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_row   <= r_row;
            r_o_col   <= r_col;
            r_o_edge  <= cur_bit;
            r_o_last  <= last_now;
            r_o_gdone <= done_now;
        end
    end

endmodule

/* sv/graph6_adjacency_decoder.sv */
// Throughput: one result per cycle while the output is not stalled; a data byte
// yields one result per payload bit (up to six), a header or ignored byte none.
// The expansion stage sets the sustained rate; a 2-entry queue and the input
// register absorb bytes while it works. Reset (synchronous, active low) empties
// all stages and leaves no graph pending.
// ----------------------------------------------------------------------------
// graph6_adjacency_decoder
// Decodes a graph6 byte stream into lower-triangle adjacency results.
// ----------------------------------------------------------------------------
module graph6_adjacency_decoder import g6ad_pkg::*; #(
    parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_frame_start,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_row,
    output logic [IDX_W-1:0]  o_col,
    output logic              o_edge_res,
    output logic              o_last_of_byte,
    output logic              o_graph_done
);

    logic      push;
    logic      pop;
    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;

    g6ad_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_byte_in    (i_byte_in),
        .i_frame_start(i_frame_start),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .i_q_status   (q_status)
    );

    g6ad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_status(q_status)
    );

    g6ad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_row         (o_row),
        .o_col         (o_col),
        .o_edge_res    (o_edge_res),
        .o_last_of_byte(o_last_of_byte),
        .o_graph_done  (o_graph_done)
    );

endmodule

/* tb/graph6_adjacency_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph6_adjacency_decoder_tb
// Self-checking bench for the graph6 adjacency decoder. Header and data
// characters are offered with random gaps, and the adjacency pairs that come
// back are checked field by field against a behavioral decoder kept here.
// The bench runs directed corner cases, then well-formed graphs with random
// content mixed with truncated graphs, stray characters and raw headers,
// under three idle mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module graph6_adjacency_decoder_tb import g6ad_pkg::*;;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             edge_bit;
        logic             last;
        logic             done;
    } t_adj_pair;

    class adjacency_scoreboard;
        logic [IDX_W-1:0] vertex_count = '0;
        int unsigned      row_idx = 1;
        int unsigned      col_idx = 0;
        bit               complete = 1'b1;
        t_adj_pair        expected_pairs[$];
        int unsigned      mismatches = 0;
        int unsigned      pairs_checked = 0;
        int unsigned      graphs_done = 0;

        function int unsigned pending();
            return expected_pairs.size();
        endfunction

        function void decode_char(input logic [BYTE_W-1:0] ch, input logic start);
            int unsigned       n;
            int unsigned       k;
            logic [BYTE_W-1:0] payload;
            t_adj_pair         pair;
            if (start) begin
                n = (ch < CHAR_OFFSET) ? 0 : ch - CHAR_OFFSET;
                if (n > MAX_VERTICES_DEF) begin
                    n = MAX_VERTICES_DEF;
                end
                vertex_count = n[IDX_W-1:0];
                row_idx = 1;
                col_idx = 0;
                complete = (n < 2);
                return;
            end
            if (complete) begin
                return;
            end
            payload = ch - CHAR_OFFSET;
            for (k = 0; k < BITS_PER_CHAR && !complete; k++) begin
                pair.row = row_idx[IDX_W-1:0];
                pair.col = col_idx[IDX_W-1:0];
                pair.edge_bit = payload[TOP_BIT - k];
                pair.done = 1'b0;
                col_idx++;
                if (col_idx >= row_idx) begin
                    col_idx = 0;
                    row_idx++;
                    if (row_idx >= vertex_count) begin
                        complete = 1'b1;
                        pair.done = 1'b1;
                    end
                end
                pair.last = (k == BITS_PER_CHAR - 1) || complete;
                expected_pairs.push_back(pair);
            end
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("mismatch at %0t ns: %s", $time, msg);
            end
        endtask

        task check_pair(input t_adj_pair got);
            t_adj_pair want;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair row %0d col %0d", got.row, got.col));
                return;
            end
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (got.row !== want.row) begin
                report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
            end
            if (got.col !== want.col) begin
                report_mismatch($sformatf("col %0d, want %0d", got.col, want.col));
            end
            if (got.edge_bit !== want.edge_bit) begin
                report_mismatch($sformatf("edge %b, want %b at row %0d col %0d",
                                          got.edge_bit, want.edge_bit, want.row, want.col));
            end
            if (got.last !== want.last) begin
                report_mismatch($sformatf("last_of_byte %b, want %b at row %0d col %0d",
                                          got.last, want.last, want.row, want.col));
            end
            if (got.done !== want.done) begin
                report_mismatch($sformatf("graph_done %b, want %b at row %0d col %0d",
                                          got.done, want.done, want.row, want.col));
            end
            if (want.done) begin
                graphs_done++;
            end
        endtask
    endclass

    localparam int unsigned HOLD_OFF_AT     = 160;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES    = 40;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [BYTE_W-1:0] i_byte_in = '0;
    logic              i_frame_start = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b1;
    logic [IDX_W-1:0]  o_row;
    logic [IDX_W-1:0]  o_col;
    logic              o_edge_res;
    logic              o_last_of_byte;
    logic              o_graph_done;

    adjacency_scoreboard sb = new;

    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 57;
    int unsigned requests_taken = 0;

    graph6_adjacency_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_in      (i_byte_in),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row          (o_row),
        .o_col          (o_col),
        .o_edge_res     (o_edge_res),
        .o_last_of_byte (o_last_of_byte),
        .o_graph_done   (o_graph_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [BYTE_W-1:0] random_char();
        if ($urandom_range(0, 99) < 85) begin
            return 8'(CHAR_OFFSET + $urandom_range(0, 63));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_request(input logic [BYTE_W-1:0] ch, input logic start);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_byte_in <= ch;
        i_frame_start <= start;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.decode_char(ch, start);
        requests_taken++;
    endtask

    task automatic send_graph(input int unsigned n, input int unsigned chars);
        send_request(8'(CHAR_OFFSET + n), 1'b1);
        repeat (chars) send_request(random_char(), 1'b0);
    endtask

    task automatic send_random_graph();
        int unsigned kind;
        int unsigned n;
        int unsigned full_chars;
        kind = $urandom_range(0, 99);
        n = $urandom_range(2, 14);
        full_chars = (n * (n - 1) / 2 + BITS_PER_CHAR - 1) / BITS_PER_CHAR;
        if (kind < 70) begin
            send_graph(n, full_chars);
        end else if (kind < 80) begin
            send_graph(n, full_chars + $urandom_range(1, 2));
        end else if (kind < 90) begin
            send_graph(n, $urandom_range(0, full_chars - 1));
        end else begin
            send_request(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 4)) send_request(random_char(), 1'b0);
        end
    endtask

    // stimulus
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(8'd126, 1'b0);
        send_request(8'd0, 1'b0);
        send_request(8'd0, 1'b1);
        send_request(8'd126, 1'b0);
        send_request(8'd64, 1'b1);
        send_request(8'd95, 1'b0);
        send_request(8'd65, 1'b1);
        send_request(8'd95, 1'b0);
        send_request(8'd126, 1'b0);
        send_request(8'd255, 1'b1);
        send_request(8'd0, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd126, 1'b0);
        send_request(8'd63, 1'b0);
        send_request(8'd68, 1'b1);
        send_request(8'd126, 1'b0);
        send_request(8'd100, 1'b0);
        send_request(8'd70, 1'b0);
        send_request(8'd66, 1'b1);
        send_request(8'd126, 1'b0);
        send_request(8'd125, 1'b1);
        send_request(8'd64, 1'b0);

        while (requests_taken < 100) send_random_graph();
        send_idle_pct = 57;
        recv_idle_pct = 33;
        while (requests_taken < 170) send_random_graph();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_graph(MAX_VERTICES_DEF,
                   (MAX_VERTICES_DEF * (MAX_VERTICES_DEF - 1) / 2 + BITS_PER_CHAR - 1)
                   / BITS_PER_CHAR);
        while (requests_taken < 500) send_random_graph();
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d input characters, %0d adjacency pairs, %0d complete graphs",
                 requests_taken, sb.pairs_checked, sb.graphs_done);
        $display("idle mixes 33/57, 57/33 and none, plus one %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side
    initial begin
        int unsigned hold_left;
        bit          hold_started;
        hold_left = 0;
        hold_started = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
                sb.check_pair('{o_row, o_col, o_edge_res, o_last_of_byte, o_graph_done});
            end
            if (!hold_started && requests_taken >= HOLD_OFF_AT) begin
                hold_started = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no transfer for %0d cycles, %0d pairs still awaited",
                 WATCHDOG_LIMIT, sb.pending());
        $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/g6ad_pkg.sv
sv/g6ad_front.sv
sv/g6ad_queue.sv
sv/g6ad_back.sv
sv/graph6_adjacency_decoder.sv
tb/graph6_adjacency_decoder_tb.sv
